FILE: src/shear_diffusion_layer_assert.svh
// Assertion macros for the shear diffusion layer.
// Both forms sample on clk and are disabled while arst_n is low.
`ifndef SHEAR_DIFFUSION_LAYER_ASSERT_SVH
`define SHEAR_DIFFUSION_LAYER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SDL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/sdl_pkg.sv
package sdl_pkg;

	localparam int unsigned NumStages = 4;
	localparam int unsigned NumPairs  = 8;
	localparam int unsigned NumBytes  = 16;

	localparam logic [63:0] BaseMatrixReset = 64'hC873_F514_01C0_DE82;
	localparam logic [7:0]  KeepMaskReset   = 8'hFF;

	typedef enum logic [1:0] {
		REG_BASE_MATRIX    = 2'd0,
		REG_SCHEDULE_ROTOR = 2'd1,
		REG_KEEP_MASK      = 2'd2,
		REG_INVERSE_MODE   = 2'd3
	} cfg_reg_e;

	// row 0 is the most significant byte
	typedef logic [0:7][7:0] mat_t;
	typedef mat_t [0:3] mat_set_t;

	typedef struct packed {
		mat_set_t   mats;
		logic       rotor;
		logic [7:0] keep;
		logic       inverse;
	} cfg_t;

	typedef struct packed {
		logic [0:NumBytes-1][7:0] b;
		logic [1:0]               rnd;
	} word_t;

	// result bit (7-i) is the parity of row i and x
	function automatic logic [7:0] mat_mul(input mat_t m, input logic [7:0] x);
		logic [7:0] y;
		y = '0;
		for (int i = 0; i < 8; i++) begin
			y[7-i] = ^(m[i] & x);
		end
		return y;
	endfunction

	// quarter turn: new bit (r,c) takes old bit (7-c, r)
	function automatic mat_t mat_rotate(input mat_t m);
		mat_t o;
		o = '0;
		for (int r = 0; r < 8; r++) begin
			for (int c = 0; c < 8; c++) begin
				o[r][7-c] = m[7-c][7-r];
			end
		end
		return o;
	endfunction

	// low byte index of pair p in stage s: p with a zero slotted in at bit s
	function automatic logic [3:0] pair_low(input int unsigned s, input int unsigned p);
		int unsigned v;
		v = ((p >> s) << (s + 1)) | (p & ((1 << s) - 1));
		return 4'(v);
	endfunction

endpackage

FILE: src/sdl_in_if.sv
interface sdl_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] state_high;
	logic [63:0] state_low;
	logic [1:0]  round_phase;

	modport source(output valid, output state_high, output state_low,
		output round_phase, input ready);
	modport sink(input valid, input state_high, input state_low,
		input round_phase, output ready);
endinterface

FILE: src/sdl_out_if.sv
interface sdl_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_high;
	logic [63:0] result_low;

	modport source(output valid, output result_high, output result_low, input ready);
	modport sink(input valid, input result_high, input result_low, output ready);
endinterface

FILE: src/shear_diffusion_layer.sv
// An accepted input word is registered in each stage cell in turn before it leaves as a result word.
// Throughput: one word per cycle while dout.ready holds; the four stage cells form a pipeline in
// which each register moves on when its successor is empty or draining.
// Reset clears the stage valid bits and loads the register defaults:
// base matrix 0xC873F51401C0DE82, rotor off, all pairs kept, forward mode.
module shear_diffusion_layer
	import sdl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	sdl_in_if.sink           din,
	sdl_out_if.source        dout,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [63:0]      cfg_wdata
);

	`include "shear_diffusion_layer_assert.svh"

	logic [63:0] base_q;
	logic        rotor_q;
	logic [7:0]  keep_q;
	logic        inverse_q;
	cfg_t        cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= BaseMatrixReset;
			rotor_q   <= 1'b0;
			keep_q    <= KeepMaskReset;
			inverse_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_BASE_MATRIX:    base_q    <= cfg_wdata;
				REG_SCHEDULE_ROTOR: rotor_q   <= cfg_wdata[0];
				REG_KEEP_MASK:      keep_q    <= cfg_wdata[7:0];
				REG_INVERSE_MODE:   inverse_q <= cfg_wdata[0];
			endcase
		end
	end

	always_comb begin
		cfg.mats[0] = mat_t'(base_q);
		for (int i = 1; i < 4; i++) begin
			cfg.mats[i] = mat_rotate(cfg.mats[i-1]);
		end
		cfg.rotor   = rotor_q;
		cfg.keep    = keep_q;
		cfg.inverse = inverse_q;
	end

	logic [NumStages:0] vld;
	logic [NumStages:0] rdy;
	word_t              wrd [NumStages+1];

	assign vld[0]     = din.valid;
	assign din.ready  = rdy[0];
	assign wrd[0].b   = {din.state_high, din.state_low};
	assign wrd[0].rnd = din.round_phase;

	for (genvar g = 0; g < NumStages; g++) begin : g_cell
		sdl_cell #(
			.POS(g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cfg     (cfg),
			.up_valid(vld[g]),
			.up_ready(rdy[g]),
			.up_word (wrd[g]),
			.dn_valid(vld[g+1]),
			.dn_ready(rdy[g+1]),
			.dn_word (wrd[g+1])
		);
	end

	assign rdy[NumStages] = dout.ready;
	assign dout.valid     = vld[NumStages];
	assign dout.result_high = wrd[NumStages].b[0:7];
	assign dout.result_low  = wrd[NumStages].b[8:15];

	// words in flight, for checking only
	logic [2:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(din.valid && din.ready)
				- 3'(dout.valid && dout.ready);
		end
	end

	`SDL_ASSERT_NOW(a_inflight_count, 1'b1, inflight_q == 3'($countones(vld[NumStages:1])), "stage valid bits disagree with words in flight")
	`SDL_ASSERT_NOW(a_ready_has_room, din.ready, !(&vld[NumStages:1]) || dout.ready, "input ready with a full stalled pipeline")
	`SDL_ASSERT_NEXT(a_take_fills_first, din.valid && din.ready, vld[1], "accepted word missing from first stage")

endmodule

FILE: src/sdl_cell.sv
module sdl_cell
	import sdl_pkg::*;
#(
	parameter int unsigned POS = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  up_valid,
	output logic  up_ready,
	input  word_t up_word,
	output logic  dn_valid,
	input  logic  dn_ready,
	output word_t dn_word
);

	localparam int unsigned StFwd = POS;
	localparam int unsigned StInv = NumStages - 1 - POS;

	logic  valid_s1;
	word_t word_s1;
	word_t nxt;

	always_comb begin
		logic [1:0] st;
		logic [3:0] li;
		logic [3:0] ri;
		logic [1:0] k;
		logic [7:0] lb;
		logic [7:0] rb;
		st  = cfg.inverse ? 2'(StInv) : 2'(StFwd);
		nxt = up_word;
		for (int p = 0; p < NumPairs; p++) begin
			li = cfg.inverse ? pair_low(StInv, p) : pair_low(StFwd, p);
			ri = cfg.inverse ? (li ^ 4'(1 << StInv)) : (li ^ 4'(1 << StFwd));
			k  = cfg.rotor ? 2'(up_word.rnd + st + 2'(p)) : 2'd0;
			lb = up_word.b[li];
			rb = up_word.b[ri];
			// the three shears read the same forwards and backwards
			lb = lb ^ mat_mul(cfg.mats[k], rb);
			rb = rb ^ mat_mul(cfg.mats[k ^ 2'd1], lb);
			lb = lb ^ mat_mul(cfg.mats[k], rb);
			// cleared pairs of stage 3 (the last in forward mode) pass through unsheared
			if (!(st == 2'(NumStages - 1) && !cfg.keep[p])) begin
				nxt.b[li] = lb;
				nxt.b[ri] = rb;
			end
		end
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_word  = word_s1;

endmodule
